// ===== src/ring_buffer_moving_average_defines.svh =====
// Assertion macros shared by the moving average block.
`ifndef RING_BUFFER_MOVING_AVERAGE_DEFINES_SVH
`define RING_BUFFER_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rbma_pkg.sv =====
`default_nettype none

package rbma_pkg;

    localparam int DATA_W         = 16;
    localparam int CFG_W          = 7;
    localparam int MAX_WINDOW_DEF = 64;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd8;

endpackage

`default_nettype wire

// ===== src/rbma_divider.sv =====
`default_nettype none

module rbma_divider #(
    parameter int SUM_W = 23,
    parameter int CNT_W = 7
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [SUM_W-1:0]            i_dividend,
    input  wire logic        [CNT_W-1:0]            i_divisor,
    output logic                                    o_done,
    output logic signed [rbma_pkg::DATA_W-1:0]      o_quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [SUM_W-1:0]     r_quo, n_quo;
    logic [CNT_W:0]       r_rem, n_rem;
    logic [CNT_W-1:0]     r_div, n_div;
    logic                 r_neg, n_neg;

    logic [SUM_W-1:0]     mag;
    logic [CNT_W:0]       rem_shift;
    logic [CNT_W:0]       diff;
    logic                 fits;
    logic [rbma_pkg::DATA_W-1:0] quo_low;

    assign mag       = i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
    assign rem_shift = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
    assign fits      = (rem_shift >= {1'b0, r_div});
    assign diff      = rem_shift - {1'b0, r_div};

    // One restoring step per cycle: the dividend shifts out at the top while
    // quotient bits shift in at the bottom.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(SUM_W);
            n_quo  = mag;
            n_rem  = '0;
            n_div  = i_divisor;
            n_neg  = i_dividend[SUM_W-1];
        end else if (r_busy) begin
            n_quo  = {r_quo[SUM_W-2:0], fits};
            n_rem  = fits ? diff : rem_shift;
            n_step = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    // The magnitude of a mean never exceeds 32768, so the low bits suffice.
    assign quo_low    = r_quo[rbma_pkg::DATA_W-1:0];
    assign o_quotient = r_neg ? -quo_low : quo_low;
    assign o_done     = r_done;

endmodule

`default_nettype wire

// ===== src/ring_buffer_moving_average.sv =====
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ----------------------------
// in        input      i_in_valid / o_in_stall   i_sample   (signed 16 bits)
// out       output     o_out_valid / i_out_stall o_mean     (signed 16 bits)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (window, 7 bits)
//
// For each item, n being the effective window, the block makes one store read
// per entry through the single read port, then the restoring divider yields one
// bit per cycle (SUM_W = 23 for a 64-entry store).
// After reset the store is zeroed one entry a cycle, all MAX_WINDOW entries, with
// input requests stalled; configuration writes are taken throughout.
// A finished mean waits in the output register while the next request is taken.
`default_nettype none

`include "ring_buffer_moving_average_defines.svh"

module ring_buffer_moving_average #(
    parameter int MAX_WINDOW = rbma_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [rbma_pkg::DATA_W-1:0]  i_sample,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [rbma_pkg::DATA_W-1:0]       o_mean,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic        [rbma_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = rbma_pkg::DATA_W + CW;
    localparam int WW = (CW > rbma_pkg::CFG_W) ? CW : rbma_pkg::CFG_W;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_WRITE  = 6'b000100,
        S_SUM    = 6'b001000,
        S_DIVIDE = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state                              r_state, n_state;
    logic [rbma_pkg::CFG_W-1:0]          r_window, n_window;
    logic [CW-1:0]                       r_n, n_n;
    logic [AW-1:0]                       r_pos, n_pos;
    logic [AW-1:0]                       r_wpos, n_wpos;
    logic signed [rbma_pkg::DATA_W-1:0]  r_sample, n_sample;
    logic [CW-1:0]                       r_addr, n_addr;
    logic                                r_rd_pend, n_rd_pend;
    logic signed [SW-1:0]                r_acc, n_acc;
    logic                                r_div_start, n_div_start;
    logic                                r_out_valid, n_out_valid;
    logic signed [rbma_pkg::DATA_W-1:0]  r_mean, n_mean;
    logic signed [rbma_pkg::DATA_W-1:0]  r_rdata;

    logic signed [rbma_pkg::DATA_W-1:0]  mem [MAX_WINDOW];

    logic [WW-1:0]                       window_ext;
    logic [CW-1:0]                       eff_n;
    logic [AW-1:0]                       pos_eff;
    logic [CW-1:0]                       pos_inc;
    logic [AW-1:0]                       pos_after;
    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    logic signed [rbma_pkg::DATA_W-1:0]  mem_wdata;
    logic                                mem_re;
    logic                                div_done;
    logic signed [rbma_pkg::DATA_W-1:0]  div_quot;

    // A window of zero counts as one, and one above the store as the whole store.
    assign window_ext = WW'(r_window);
    always_comb begin
        if (r_window == '0) begin
            eff_n = CW'(1);
        end else if (window_ext > WW'(MAX_WINDOW)) begin
            eff_n = CW'(MAX_WINDOW);
        end else begin
            eff_n = CW'(r_window);
        end
    end

    // A position left beyond a lowered window restarts at entry zero.
    assign pos_eff   = (CW'(r_pos) >= eff_n) ? '0 : r_pos;
    assign pos_inc   = CW'(r_wpos) + CW'(1);
    assign pos_after = (pos_inc >= r_n) ? '0 : AW'(pos_inc);

    always_comb begin
        n_state     = r_state;
        n_window    = r_window;
        n_n         = r_n;
        n_pos       = r_pos;
        n_wpos      = r_wpos;
        n_sample    = r_sample;
        n_addr      = r_addr;
        n_rd_pend   = 1'b0;
        n_acc       = r_acc;
        n_div_start = 1'b0;
        n_out_valid = r_out_valid;
        n_mean      = r_mean;

        if (i_cfg_valid) begin
            n_window = i_cfg_data;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + CW'(1);
                if (r_addr == CW'(MAX_WINDOW - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sample = i_sample;
                    n_n      = eff_n;
                    n_wpos   = pos_eff;
                    n_state  = S_WRITE;
                end
            end
            S_WRITE: begin
                n_pos   = pos_after;
                n_addr  = '0;
                n_acc   = '0;
                n_state = S_SUM;
            end
            S_SUM: begin
                // Reads are issued one a cycle; each lands in the cycle after it is issued.
                if (r_addr != r_n) begin
                    n_addr    = r_addr + CW'(1);
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    n_acc = r_acc + SW'(r_rdata);
                end
                if (r_addr == r_n && r_rd_pend) begin
                    n_div_start = 1'b1;
                    n_state     = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_mean      = div_quot;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_window    <= rbma_pkg::WINDOW_RESET;
            r_pos       <= '0;
            r_addr      <= '0;
            r_rd_pend   <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_pos       <= n_pos;
            r_addr      <= n_addr;
            r_rd_pend   <= n_rd_pend;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
        r_n      <= n_n;
        r_wpos   <= n_wpos;
        r_sample <= n_sample;
        r_acc    <= n_acc;
        r_mean   <= n_mean;
    end

    // Sample store: one write port shared by the clearing pass and new samples.
    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign mem_waddr = (r_state == S_CLEAR) ? r_addr[AW-1:0] : r_wpos;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : r_sample;
    assign mem_re    = (r_state == S_SUM) && (r_addr != r_n);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[r_addr[AW-1:0]];
        end
    end

    rbma_divider #(
        .SUM_W (SW),
        .CNT_W (CW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_mean      = r_mean;
    assign o_cfg_ready = 1'b1;

    `RBMA_ASSERT_NXT(a_accept_starts_write, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_WRITE && o_in_stall, "accepted request did not start a store write")
    `RBMA_ASSERT_IMP(a_sum_in_window, i_clk, i_rst_n, r_state == S_SUM, r_addr <= r_n, "sum read address ran past the window")
    `RBMA_ASSERT_IMP(a_div_done_in_state, i_clk, i_rst_n, div_done, r_state == S_DIVIDE, "divider finished outside the divide state")
    `RBMA_ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_DONE), "output loaded without a finished mean")

endmodule

`default_nettype wire

// ===== tb/sv/moving_average_checker.sv =====
`timescale 1ns / 100ps

module moving_average_checker #(
    parameter int STORE_DEPTH = rbma_pkg::MAX_WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic signed [rbma_pkg::DATA_W-1:0] i_sample,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [rbma_pkg::DATA_W-1:0] i_mean,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic        [rbma_pkg::CFG_W-1:0]  i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_request_count,
    output int                                 o_mean_count
);
    import rbma_pkg::*;

    typedef logic signed [DATA_W-1:0] sample_t;

    sample_t          sample_history [STORE_DEPTH];
    int               next_slot;
    logic [CFG_W-1:0] window_reg;
    sample_t          pending_means [$];
    sample_t          oldest_mean;

    // Writes the sample into the history and returns the truncated mean of the window.
    function automatic sample_t insert_and_average(input sample_t new_sample);
        int span;
        int slot;
        int total;
        span = int'(window_reg);
        if (span == 0) begin
            span = 1;
        end
        if (span > STORE_DEPTH) begin
            span = STORE_DEPTH;
        end
        slot = next_slot;
        // A window lowered below the position restarts writing at the first entry.
        if (slot >= span) begin
            slot = 0;
        end
        sample_history[slot] = new_sample;
        total = 0;
        for (int k = 0; k < span; k++) begin
            total += int'(sample_history[k]);
        end
        slot++;
        if (slot >= span) begin
            slot = 0;
        end
        next_slot = slot;
        return sample_t'(total / span);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                sample_history[k] = '0;
            end
            next_slot = 0;
            window_reg = WINDOW_RESET;
            pending_means.delete();
            o_fail_count <= 0;
            o_request_count <= 0;
            o_mean_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                window_reg = i_cfg_data;
            end
            // The result is checked before this edge's request is added, so a mean can
            // never be matched against the request taken in the same cycle.
            if (i_out_valid && !i_out_stall) begin
                o_mean_count <= o_mean_count + 1;
                if (pending_means.size() == 0) begin
                    $error("mean arrived with no request outstanding: actual %0d", i_mean);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    oldest_mean = pending_means.pop_front();
                    if (i_mean !== oldest_mean) begin
                        $error("mean mismatch: expected %0d, actual %0d", oldest_mean, i_mean);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_means.push_back(insert_and_average(i_sample));
                o_request_count <= o_request_count + 1;
            end
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import rbma_pkg::*;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int TARGET_SAMPLES = 500;
    localparam int HOLD_AFTER     = 160;
    localparam int HOLD_CYCLES    = 400;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] sample    = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] mean;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic        [CFG_W-1:0]  cfg_data  = '0;

    int fail_count;
    int request_count;
    int mean_count;
    int samples_offered = 0;
    int burst_left      = 0;
    int windows_written = 0;

    int hold_left = 0;
    bit hold_done = 1'b0;
    int pattern_left = 0;
    int stall_percent = 0;

    ring_buffer_moving_average u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_sample    (sample),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_mean      (mean),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    moving_average_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_sample        (sample),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_mean          (mean),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_request_count (request_count),
        .o_mean_count    (mean_count)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: random stall patterns, plus one long hold-off once the run is under way.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!hold_done && request_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(5, 60);
                case ($urandom_range(0, 3))
                    0: stall_percent = 0;
                    1: stall_percent = 20;
                    2: stall_percent = 50;
                    default: stall_percent = 85;
                endcase
            end else begin
                pattern_left--;
            end
            out_stall <= ($urandom_range(0, 99) < stall_percent);
        end
    end

    function automatic logic [DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return DATA_W'($urandom_range(0, 15) - 8);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Offers one request and waits for it to be taken; three bursts in four end in a random gap.
    task automatic offer_sample(input logic [DATA_W-1:0] value);
        int gap;
        in_valid <= 1'b1;
        sample <= value;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        samples_offered++;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 25);
            end
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic offer_random(input int count);
        for (int k = 0; k < count; k++) begin
            offer_sample(pick_sample());
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (request_count != mean_count) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The window is only changed once every mean has been delivered.
    task automatic write_window(input logic [CFG_W-1:0] width);
        drain_results();
        cfg_data <= width;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        windows_written++;
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("ring_buffer_moving_average: mismatch");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] next_window;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset window of eight: full-scale ramps, then truncation toward zero.
        repeat (8) offer_sample(16'h7FFF);
        repeat (8) offer_sample(16'h8000);
        offer_sample(16'hFFFF);
        repeat (7) offer_sample(16'h0000);

        write_window(7'd64);
        offer_random(45);
        // Shrinking the window leaves the position beyond it.
        write_window(7'd8);
        offer_random(12);
        write_window(7'd1);
        offer_random(25);
        write_window(7'd0);
        offer_random(15);
        write_window(7'd127);
        offer_random(80);
        write_window(7'd65);
        offer_random(20);
        write_window(7'd2);
        offer_random(25);

        while (samples_offered < TARGET_SAMPLES) begin
            case ($urandom_range(0, 7))
                0: next_window = CFG_W'($urandom_range(0, 127));
                1: next_window = 7'd64;
                default: next_window = CFG_W'($urandom_range(1, 16));
            endcase
            write_window(next_window);
            offer_random($urandom_range(10, 40));
        end

        drain_results();
        $display("Covered %0d requests and %0d means over %0d window writes.",
                 request_count, mean_count, windows_written);
        $display("Windows included zero, oversized, shrinking and full-store settings.");
        if (fail_count == 0 && request_count == mean_count) begin
            $display("ring_buffer_moving_average: match");
        end else begin
            $display("ring_buffer_moving_average: mismatch");
        end
        $finish;
    end

endmodule
